// File: sv/a2dmb_pkg.sv
// Shared types and constants for the 2D affine matrix builder.
// No dependencies.
`default_nettype none

package a2dmb_pkg;

  typedef struct packed {
    logic signed [15:0] rotation_angle;
    logic signed [15:0] scale_x;
    logic signed [15:0] scale_y;
    logic signed [23:0] origin_x;
    logic signed [23:0] origin_y;
    logic signed [23:0] position_x;
    logic signed [23:0] position_y;
  } xform_t;

  typedef struct packed {
    logic signed [15:0] m00;
    logic signed [15:0] m01;
    logic signed [15:0] m10;
    logic signed [15:0] m11;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
  } matrix_t;

  // pi in Q30
  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam int SERIES_TERMS = 10;
  // (2n)(2n+1) divisors of the sine series
  localparam longint unsigned SERIES_DIV [SERIES_TERMS] =
    '{64'd1, 64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342};
  localparam int RECIP_SHIFT = 32;
  localparam int TRANS_FRAC = 8;

endpackage

`default_nettype wire

// File: sv/affine_2d_matrix_builder.sv
// Top level of the 2D affine matrix builder: angle reduction, quarter-wave sine ROM,
// scale/rotation products and saturated translation. Depends on a2dmb_pkg.
`default_nettype none

// Usage:
//   Input channel: drive an item on xform and raise start. The item is taken at
//   a rising edge with start high and busy low; busy is always low, so one item
//   can be taken every cycle.
//   Output channel: done is high for exactly one cycle while matrix holds the
//   result for the item. The receiver has no way to stall; results must be
//   taken when done is high.
//   Path: an accepted item passes the stage 1 to stage 6 registers in turn;
//   the result and done are registered together in the output register, and
//   the result is taken while done is high.
//   Throughput: one item per cycle, items in flight overlap freely in the
//   seven-stage pipeline (reciprocal divide, quadrant split, ROM read, sign
//   fix, products, rounding, translation add and output register).
//   The sine ROM holds 90*ANGLE_STEPS_PER_DEGREE+1 entries, built at
//   elaboration, with two registered read ports.
//   Reset (rst, synchronous) clears all valid bits; items in flight are
//   dropped and no result comes out for them.
module affine_2d_matrix_builder #(
  parameter int ANGLE_STEPS_PER_DEGREE = 16,
  parameter int TRIG_FRAC_BITS = 14
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  output logic                    busy,
  input  wire a2dmb_pkg::xform_t  xform,
  output logic                    done,
  output a2dmb_pkg::matrix_t      matrix
);

  localparam int F        = TRIG_FRAC_BITS;
  localparam int QUARTER  = 90 * ANGLE_STEPS_PER_DEGREE;
  localparam int TURN     = 4 * QUARTER;
  localparam int HALF_DIV = 2 * QUARTER;
  localparam int OFF      = (TURN - (32768 % TURN)) % TURN;
  localparam int V_MAX    = 65535 + TURN - 1;
  localparam int V_W      = $clog2(V_MAX + 1);
  localparam longint unsigned RECIP =
    ((64'd1 << a2dmb_pkg::RECIP_SHIFT) + 64'(QUARTER) - 64'd1) / 64'(QUARTER);
  localparam int RECIP_W  = $clog2(RECIP + 1);
  localparam int PW       = V_W + RECIP_W;
  localparam int QD_W     = PW - a2dmb_pkg::RECIP_SHIFT;
  localparam int K_W      = $clog2(QUARTER + 1);
  localparam int TW       = F + 2;
  localparam int PM_W     = 16 + TW;
  localparam int OS_W     = 40;
  localparam int AX_W     = OS_W + TW;
  localparam int A_W      = AX_W + 2;
  localparam int RS_W     = A_W - F - a2dmb_pkg::TRANS_FRAC;
  localparam int TX_W     = RS_W + 1;

  typedef logic [F:0] trig_t;
  typedef trig_t rom_t [QUARTER+1];

  function automatic rom_t build_rom();
    rom_t rom;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint sum;
    for (int k = 0; k <= QUARTER; k++) begin
      if (k == 0) begin
        rom[k] = '0;
      end else if (k == QUARTER) begin
        rom[k] = trig_t'(64'd1 << F);
      end else begin
        x   = (a2dmb_pkg::PI_Q30 * 64'(k)) / HALF_DIV;
        x2  = (x * x) >> 30;
        t   = x;
        sum = longint'(x);
        for (int n = 1; n < a2dmb_pkg::SERIES_TERMS; n++) begin
          t = ((t * x2) >> 30) / a2dmb_pkg::SERIES_DIV[n];
          if (n % 2 == 1) sum = sum - longint'(t);
          else sum = sum + longint'(t);
        end
        if (sum < 0) sum = 0;
        rom[k] = trig_t'((sum + (64'sd1 <<< (29 - F))) >>> (30 - F));
      end
    end
    return rom;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  function automatic logic signed [15:0] round_sat16(input logic signed [PM_W-1:0] p);
    logic signed [PM_W:0] r;
    r = ((PM_W+1)'(p) + (PM_W+1)'(1 <<< (F - 1))) >>> F;
    if (r > (PM_W+1)'(32767)) return 16'sh7fff;
    else if (r < -(PM_W+1)'(32768)) return -16'sh8000;
    else return r[15:0];
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [TX_W-1:0] v);
    if (v > TX_W'(64'sd2147483647)) return 32'sh7fffffff;
    else if (v < -TX_W'(64'sd2147483648)) return -32'sh80000000;
    else return v[31:0];
  endfunction

  // stage 1: angle offset and reciprocal multiply, origin times scale
  logic [15:0]            ang_u;
  logic [V_W-1:0]         ang_v;
  logic [PW-1:0]          prod;
  logic                   v1;
  logic [V_W-1:0]         av1;
  logic [QD_W-1:0]        qd1;
  logic signed [15:0]     sx1, sy1;
  logic signed [23:0]     px1, py1;
  logic signed [OS_W-1:0] oxsx1, oysy1;

  assign ang_u = {~xform.rotation_angle[15], xform.rotation_angle[14:0]};
  assign ang_v = V_W'(ang_u) + V_W'(OFF);
  assign prod  = PW'(ang_v) * PW'(RECIP);

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else v1 <= start;
    av1   <= ang_v;
    qd1   <= prod[PW-1:a2dmb_pkg::RECIP_SHIFT];
    sx1   <= xform.scale_x;
    sy1   <= xform.scale_y;
    px1   <= xform.position_x;
    py1   <= xform.position_y;
    oxsx1 <= OS_W'(xform.origin_x) * OS_W'(xform.scale_x);
    oysy1 <= OS_W'(xform.origin_y) * OS_W'(xform.scale_y);
  end

  // stage 2: remainder within the quarter and quadrant
  logic [V_W-1:0]         qdq;
  logic [V_W-1:0]         rem;
  logic                   v2;
  logic [K_W-1:0]         k2, kc2;
  logic [1:0]             quad2;
  logic signed [15:0]     sx2, sy2;
  logic signed [23:0]     px2, py2;
  logic signed [OS_W-1:0] oxsx2, oysy2;

  assign qdq = V_W'(qd1) * V_W'(QUARTER);
  assign rem = av1 - qdq;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else v2 <= v1;
    k2    <= rem[K_W-1:0];
    kc2   <= K_W'(QUARTER) - rem[K_W-1:0];
    quad2 <= qd1[1:0];
    sx2   <= sx1;
    sy2   <= sy1;
    px2   <= px1;
    py2   <= py1;
    oxsx2 <= oxsx1;
    oysy2 <= oysy1;
  end

  // stage 3: sine ROM, two registered reads
  logic                   v3;
  trig_t                  ta3, tb3;
  logic [1:0]             quad3;
  logic signed [15:0]     sx3, sy3;
  logic signed [23:0]     px3, py3;
  logic signed [OS_W-1:0] oxsx3, oysy3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else v3 <= v2;
    ta3   <= SINE_ROM[k2];
    tb3   <= SINE_ROM[kc2];
    quad3 <= quad2;
    sx3   <= sx2;
    sy3   <= sy2;
    px3   <= px2;
    py3   <= py2;
    oxsx3 <= oxsx2;
    oysy3 <= oysy2;
  end

  // stage 4: s = -sin r, c = cos r
  logic signed [TW-1:0]   ssel, csel, s_next, c_next;
  logic                   v4;
  logic signed [TW-1:0]   s4, c4;
  logic signed [15:0]     sx4, sy4;
  logic signed [23:0]     px4, py4;
  logic signed [OS_W-1:0] oxsx4, oysy4;

  assign ssel   = quad3[0] ? $signed({1'b0, tb3}) : $signed({1'b0, ta3});
  assign csel   = quad3[0] ? $signed({1'b0, ta3}) : $signed({1'b0, tb3});
  assign s_next = quad3[1] ? ssel : -ssel;
  assign c_next = (quad3[1] ^ quad3[0]) ? -csel : csel;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else v4 <= v3;
    s4    <= s_next;
    c4    <= c_next;
    sx4   <= sx3;
    sy4   <= sy3;
    px4   <= px3;
    py4   <= py3;
    oxsx4 <= oxsx3;
    oysy4 <= oysy3;
  end

  // stage 5: products
  logic                   v5;
  logic signed [PM_W-1:0] pxc5, pys5, pxs5, pyc5;
  logic signed [AX_W-1:0] ax5, ay5, bx5, by5;
  logic signed [23:0]     px5, py5;

  always_ff @(posedge clk) begin
    if (rst) v5 <= 1'b0;
    else v5 <= v4;
    pxc5 <= PM_W'(sx4) * PM_W'(c4);
    pys5 <= PM_W'(sy4) * PM_W'(s4);
    pxs5 <= PM_W'(sx4) * PM_W'(s4);
    pyc5 <= PM_W'(sy4) * PM_W'(c4);
    ax5  <= AX_W'(oxsx4) * AX_W'(c4);
    ay5  <= AX_W'(oysy4) * AX_W'(s4);
    bx5  <= AX_W'(oxsx4) * AX_W'(s4);
    by5  <= AX_W'(oysy4) * AX_W'(c4);
    px5  <= px4;
    py5  <= py4;
  end

  // stage 6: matrix entries rounded and saturated, translation sums rounded
  logic signed [A_W-1:0]  a_sum, b_sum, a_rnd, b_rnd;
  logic                   v6;
  logic signed [15:0]     m00_6, m01_6, m10_6, m11_6;
  logic signed [RS_W-1:0] ar6, br6;
  logic signed [23:0]     px6, py6;

  assign a_sum = -A_W'(ax5) - A_W'(ay5);
  assign b_sum = A_W'(bx5) - A_W'(by5);
  assign a_rnd = (a_sum + A_W'(1 <<< (F + a2dmb_pkg::TRANS_FRAC - 1)))
                 >>> (F + a2dmb_pkg::TRANS_FRAC);
  assign b_rnd = (b_sum + A_W'(1 <<< (F + a2dmb_pkg::TRANS_FRAC - 1)))
                 >>> (F + a2dmb_pkg::TRANS_FRAC);

  always_ff @(posedge clk) begin
    if (rst) v6 <= 1'b0;
    else v6 <= v5;
    m00_6 <= round_sat16(pxc5);
    m01_6 <= round_sat16(pys5);
    m10_6 <= round_sat16(-pxs5);
    m11_6 <= round_sat16(pyc5);
    ar6   <= a_rnd[RS_W-1:0];
    br6   <= b_rnd[RS_W-1:0];
    px6   <= px5;
    py6   <= py5;
  end

  // output register: add position, saturate
  logic signed [TX_W-1:0] tx_sum, ty_sum;

  assign tx_sum = TX_W'(ar6) + TX_W'(px6);
  assign ty_sum = TX_W'(br6) + TX_W'(py6);

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else done <= v6;
    matrix.m00     <= m00_6;
    matrix.m01     <= m01_6;
    matrix.m10     <= m10_6;
    matrix.m11     <= m11_6;
    matrix.trans_x <= sat32(tx_sum);
    matrix.trans_y <= sat32(ty_sum);
  end

  assign busy = 1'b0;

`ifndef SYNTH
  a_done_from_start: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start, 7))
    else $error("result strobe without an item seven cycles earlier");

  a_start_to_done: assert property (@(posedge clk) disable iff (rst)
    start && !busy |-> ##7 done)
    else $error("accepted item produced no result");

  a_k_in_quarter: assert property (@(posedge clk) disable iff (rst)
    v2 |-> k2 < K_W'(QUARTER))
    else $error("angle remainder outside the quarter");

  a_trig_bounded: assert property (@(posedge clk) disable iff (rst)
    v4 |-> (c4 <= TW'(1 <<< F)) && (c4 >= -TW'(1 <<< F)) &&
           (s4 <= TW'(1 <<< F)) && (s4 >= -TW'(1 <<< F)))
    else $error("sine or cosine out of range");
`endif

endmodule

`default_nettype wire
